// File: sv/slq_pkg.sv
`timescale 1ns / 1ps

package slq_pkg;

	// Word and port widths.
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned ADDR_W        = 12;

	// Words in one instruction: A, B and C.
	localparam int unsigned INSN_WORDS    = 3;

	// Default size of the word memory.
	localparam int unsigned MEM_WORDS_DEF = 4096;

	// Request operation codes.
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_EXEC    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

endpackage

// File: sv/slq_mem.sv
`timescale 1ns / 1ps

module slq_mem #(
	parameter int unsigned DEPTH = slq_pkg::MEM_WORDS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [slq_pkg::DATA_W-1:0] wdata,
	output logic [slq_pkg::DATA_W-1:0] rdata
);
	import slq_pkg::*;

	// Single-port word storage; contents are undefined until written.
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// One access per cycle: a write, or a read whose data is registered.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/subleq_processor_core.sv
`timescale 1ns / 1ps

// Subleq processor over a single-port word memory of MEM_WORDS signed 32-bit words.
// Each request gives exactly one result. Every memory access goes through one port
// whose read data is registered, and one shared 32-bit adder does the address
// increments, the subtraction and the pc advance, so requests run one at a time;
// a full execute makes five reads and one write on the port.
// The result waits in an output register, so a new request can be accepted while
// the previous result is still stalled.
module subleq_processor_core #(
	parameter int unsigned MEM_WORDS = slq_pkg::MEM_WORDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic [slq_pkg::ADDR_W-1:0]        address,
	input  logic signed [slq_pkg::DATA_W-1:0] write_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [slq_pkg::DATA_W-1:0] read_data,
	output logic signed [slq_pkg::DATA_W-1:0] new_value,
	output logic                              branch_taken,
	output logic [slq_pkg::ADDR_W-1:0]        program_counter,
	output logic                              halted
);
	import slq_pkg::*;

	localparam int unsigned AW = $clog2(MEM_WORDS);
	localparam logic [DATA_W-1:0] MEM_LIM = DATA_W'(MEM_WORDS);
	localparam logic [DATA_W-1:0] PC_LAST = DATA_W'(MEM_WORDS - INSN_WORDS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_READ_WAIT,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_RD_VA,
		S_RD_VB,
		S_SUB,
		S_WRITE,
		S_DONE
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [AW-1:0]     addr_q;
	logic              addr_ok_q;
	logic [DATA_W-1:0] wdata_q;
	logic [DATA_W-1:0] pc_q;
	logic              stopped_q;
	logic [AW-1:0]     ptr_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] c_q;
	logic [DATA_W-1:0] va_q;
	logic [DATA_W-1:0] r_q;
	logic              ops_ok_q;
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] nval_q;
	logic              taken_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic [DATA_W-1:0] new_value_q;
	logic              branch_taken_q;
	logic [ADDR_W-1:0] program_counter_q;
	logic              halted_q;

	logic              accept;
	logic [DATA_W-1:0] addr_ext;
	logic              pc_ok;
	logic              a_ok;
	logic              b_ok;
	logic              out_free;
	logic              stop_next;

	logic              alu_sub;
	logic [DATA_W-1:0] alu_x;
	logic [DATA_W-1:0] alu_y;
	logic [DATA_W-1:0] alu_sum;

	logic              mem_en;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign addr_ext = {{(DATA_W-ADDR_W){1'b0}}, address};

	// A whole instruction fits at pc; operands must address memory.
	assign pc_ok = (pc_q <= PC_LAST);
	assign a_ok  = (a_q < MEM_LIM);
	assign b_ok  = (b_q < MEM_LIM);

	// The output register can take a result when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign stop_next = stopped_q || ((op_q == OP_EXEC) && !pc_ok);

	// Shared adder: pointer increments, the subtraction and the pc advance.
	always_comb begin
		alu_sub = 1'b0;
		alu_x   = pc_q;
		alu_y   = '0;
		unique case (state_q)
			S_RD_A: begin
				alu_y = DATA_W'(1);
			end
			S_RD_B: begin
				alu_x = {{(DATA_W-AW){1'b0}}, ptr_q};
				alu_y = DATA_W'(1);
			end
			S_SUB: begin
				alu_sub = 1'b1;
				alu_x   = mem_rdata;
				alu_y   = va_q;
			end
			S_WRITE: begin
				alu_y = DATA_W'(INSN_WORDS);
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + DATA_W'(alu_sub);

	// Memory port control for each sequencer step.
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pc_q[AW-1:0];
		mem_wdata = r_q;
		unique case (state_q)
			S_READ: begin
				mem_en   = addr_ok_q;
				mem_addr = addr_q;
			end
			S_RD_A: begin
				mem_en = 1'b1;
			end
			S_RD_B, S_RD_C: begin
				mem_en   = 1'b1;
				mem_addr = ptr_q;
			end
			S_RD_VA: begin
				mem_en   = a_ok && b_ok;
				mem_addr = a_q[AW-1:0];
			end
			S_RD_VB: begin
				mem_en   = 1'b1;
				mem_addr = b_q[AW-1:0];
			end
			S_WRITE: begin
				if (op_q == OP_WRITE) begin
					mem_en    = addr_ok_q;
					mem_we    = 1'b1;
					mem_addr  = addr_q;
					mem_wdata = wdata_q;
				end else begin
					mem_en   = 1'b1;
					mem_we   = 1'b1;
					mem_addr = b_q[AW-1:0];
				end
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	slq_mem #(
		.DEPTH(MEM_WORDS)
	) u_mem (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Sequencer, architectural state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_WRITE;
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= op_t'(op);
						addr_q    <= addr_ext[AW-1:0];
						addr_ok_q <= (addr_ext < MEM_LIM);
						wdata_q   <= $unsigned(write_data);
						rd_q      <= '0;
						nval_q    <= '0;
						taken_q   <= 1'b0;
						ops_ok_q  <= 1'b0;
						unique case (op_t'(op))
							OP_WRITE: begin
								state_q <= S_WRITE;
							end
							OP_READ: begin
								state_q <= S_READ;
							end
							OP_EXEC: begin
								if (stopped_q || !pc_ok) begin
									stopped_q <= 1'b1;
									state_q   <= S_DONE;
								end else begin
									state_q <= S_RD_A;
								end
							end
							OP_RESTART: begin
								pc_q      <= '0;
								stopped_q <= 1'b0;
								state_q   <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_READ_WAIT;
				end
				S_READ_WAIT: begin
					rd_q    <= addr_ok_q ? mem_rdata : '0;
					state_q <= S_DONE;
				end
				S_RD_A: begin
					ptr_q   <= alu_sum[AW-1:0];
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					a_q     <= mem_rdata;
					ptr_q   <= alu_sum[AW-1:0];
					state_q <= S_RD_C;
				end
				S_RD_C: begin
					b_q     <= mem_rdata;
					state_q <= S_RD_VA;
				end
				S_RD_VA: begin
					c_q <= mem_rdata;
					if (a_ok && b_ok) begin
						ops_ok_q <= 1'b1;
						state_q  <= S_RD_VB;
					end else begin
						pc_q    <= '0;
						state_q <= S_DONE;
					end
				end
				S_RD_VB: begin
					va_q    <= mem_rdata;
					state_q <= S_SUB;
				end
				S_SUB: begin
					r_q     <= alu_sum;
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (op_q == OP_EXEC) begin
						nval_q <= r_q;
						if ((r_q != '0) && !r_q[DATA_W-1]) begin
							pc_q <= alu_sum;
						end else begin
							pc_q    <= c_q;
							taken_q <= 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						stopped_q         <= stop_next;
						out_valid_q       <= 1'b1;
						read_data_q       <= rd_q;
						new_value_q       <= nval_q;
						branch_taken_q    <= taken_q;
						program_counter_q <= pc_q[ADDR_W-1:0];
						halted_q          <= stop_next;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = $signed(read_data_q);
	assign new_value       = $signed(new_value_q);
	assign branch_taken    = branch_taken_q;
	assign program_counter = program_counter_q;
	assign halted          = halted_q;

	// A running core that waits for a request always has a whole instruction at pc.
	a_running_pc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !stopped_q) |-> pc_ok)
		else $error("running core idles with pc out of range");

	// An executed instruction only stores to memory when both operands were in range.
	a_exec_write_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_en && op_q == OP_EXEC) |-> ops_ok_q)
		else $error("instruction store with out-of-range operand");

	// A taken branch always comes with a result that is zero or negative.
	a_taken_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && branch_taken_q) |-> (new_value_q == '0 || new_value_q[DATA_W-1]))
		else $error("branch taken on a positive result");

	// A restart request leaves the core running from address zero.
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_RESTART) |=> (pc_q == '0 && !stopped_q))
		else $error("restart did not clear pc and halt flag");

endmodule
